[hw/rtl/kcl_pkg.sv]
// Package for the keypad code lock: widths, key and event codes, CSR indexes, reset values.
// Used by keypad_code_lock_unit; no dependencies.
package kcl_pkg;

   localparam int MAX_DIGITS  = 16;
   localparam int DIGIT_W     = 4;
   localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
   localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
   localparam int TIMER_W     = 16;
   localparam int CODE_W      = MAX_DIGITS * DIGIT_W;
   localparam int LENGTH_W    = 5;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int EVENT_W     = 3;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [DIGIT_W-1:0] KEY_STAR = 4'd10;
   localparam logic [DIGIT_W-1:0] KEY_HASH = 4'd11;

   localparam logic [CSR_INDEX_W-1:0] CSR_STORED_CODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STORED_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_TIMEOUT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_TICKS    = 2'd3;

   localparam logic [TIMER_W-1:0] ENTRY_TIMEOUT_RST = 16'd5000;
   localparam logic [TIMER_W-1:0] OPEN_TICKS_RST    = 16'd10000;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE    = 3'd0,
      EV_START   = 3'd1,
      EV_ACCEPT  = 3'd2,
      EV_REJECT  = 3'd3,
      EV_TIMEOUT = 3'd4,
      EV_CLOSED  = 3'd5
   } event_type;

endpackage

[hw/rtl/keypad_code_lock_unit.sv]
// Keypad code lock: input word register, one pass of update logic, result register.
// A word's result is registered in rsp_* when the result register is empty or read.
// Throughput: one word per cycle unless rsp_ready is low; the input register holds one.
// Reset (synchronous): lock closed, entry idle, counters zero, timeout 5000, open 10000.
// Digit buffer has no reset; only digits written since the last star are compared.
// Depends on kcl_pkg.
module keypad_code_lock_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [kcl_pkg::DIGIT_W-1:0]        req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [kcl_pkg::EVENT_W-1:0]        rsp_event_res,
   output logic                               rsp_door_open,
   output logic [kcl_pkg::COUNT_W-1:0]        rsp_digit_count,
   input  logic                               csr_wr_en,
   input  logic [kcl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [kcl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // configuration
   logic [kcl_pkg::CODE_W-1:0]   stored_code_ff;
   logic [kcl_pkg::LENGTH_W-1:0] stored_length_ff;
   logic [kcl_pkg::TIMER_W-1:0]  entry_timeout_ff;
   logic [kcl_pkg::TIMER_W-1:0]  open_ticks_ff;

   // input word register
   logic                         in_valid_ff, in_valid_in;
   logic                         in_op_ff;
   logic [kcl_pkg::DIGIT_W-1:0]  in_key_ff;

   // lock state
   logic [kcl_pkg::DIGIT_W-1:0]  entry_digits_ff [kcl_pkg::MAX_DIGITS];
   logic [kcl_pkg::COUNT_W-1:0]  entry_count_ff, entry_count_in;
   logic                         entering_ff, entering_in;
   logic [kcl_pkg::TIMER_W-1:0]  idle_ticks_ff, idle_ticks_in;
   logic                         lock_open_ff, lock_open_in;
   logic [kcl_pkg::TIMER_W-1:0]  open_elapsed_ff, open_elapsed_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   kcl_pkg::event_type           rsp_event_ff, rsp_event_in;

   logic                         advance;
   logic                         digit_wr;
   logic                         code_match;
   logic                         digit_miss;
   logic                         count_full;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign count_full = entry_count_ff >= kcl_pkg::COUNT_W'(kcl_pkg::MAX_DIGITS);

   // parallel compare of the held digits against the stored nibbles
   always_comb begin
      digit_miss = 1'b0;
      for (int i = 0; i < kcl_pkg::MAX_DIGITS; i++) begin
         if ((kcl_pkg::COUNT_W'(i) < entry_count_ff) &&
             (entry_digits_ff[i] != stored_code_ff[i*kcl_pkg::DIGIT_W +: kcl_pkg::DIGIT_W])) begin
            digit_miss = 1'b1;
         end
      end
      code_match = !digit_miss && (entry_count_ff != '0) &&
                   (kcl_pkg::LENGTH_W'(entry_count_ff) == stored_length_ff) &&
                   (stored_length_ff <= kcl_pkg::LENGTH_W'(kcl_pkg::MAX_DIGITS));
   end

   always_comb begin
      entry_count_in  = entry_count_ff;
      entering_in     = entering_ff;
      idle_ticks_in   = idle_ticks_ff;
      lock_open_in    = lock_open_ff;
      open_elapsed_in = open_elapsed_ff;
      rsp_event_in    = rsp_event_ff;
      digit_wr        = 1'b0;
      if (advance) begin
         rsp_event_in = kcl_pkg::EV_NONE;
         if (in_op_ff == kcl_pkg::OP_TICK) begin
            if (lock_open_ff) begin
               if (open_elapsed_ff >= open_ticks_ff) begin
                  lock_open_in = 1'b0;
                  rsp_event_in = kcl_pkg::EV_CLOSED;
               end else begin
                  open_elapsed_in = open_elapsed_ff + 1'b1;
               end
            end else if (entering_ff) begin
               if (idle_ticks_ff >= entry_timeout_ff) begin
                  entering_in    = 1'b0;
                  entry_count_in = '0;
                  rsp_event_in   = kcl_pkg::EV_TIMEOUT;
               end else begin
                  idle_ticks_in = idle_ticks_ff + 1'b1;
               end
            end
         end else if (!lock_open_ff && (in_key_ff <= kcl_pkg::KEY_HASH)) begin
            idle_ticks_in = '0;
            if (in_key_ff == kcl_pkg::KEY_STAR) begin
               entry_count_in = '0;
               entering_in    = 1'b1;
               rsp_event_in   = kcl_pkg::EV_START;
            end else if (in_key_ff == kcl_pkg::KEY_HASH) begin
               // empty buffer or no entry: hash is ignored
               if (entering_ff && (entry_count_ff != '0)) begin
                  entering_in = 1'b0;
                  if (code_match) begin
                     lock_open_in    = 1'b1;
                     open_elapsed_in = '0;
                     rsp_event_in    = kcl_pkg::EV_ACCEPT;
                  end else begin
                     rsp_event_in = kcl_pkg::EV_REJECT;
                  end
               end
            end else if (entering_ff && !count_full) begin
               digit_wr       = 1'b1;
               entry_count_in = entry_count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_code_ff   <= '0;
         stored_length_ff <= '0;
         entry_timeout_ff <= kcl_pkg::ENTRY_TIMEOUT_RST;
         open_ticks_ff    <= kcl_pkg::OPEN_TICKS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            kcl_pkg::CSR_STORED_CODE: begin
               stored_code_ff <= csr_wdata[kcl_pkg::CODE_W-1:0];
            end
            kcl_pkg::CSR_STORED_LENGTH: begin
               stored_length_ff <= csr_wdata[kcl_pkg::LENGTH_W-1:0];
            end
            kcl_pkg::CSR_ENTRY_TIMEOUT: begin
               entry_timeout_ff <= csr_wdata[kcl_pkg::TIMER_W-1:0];
            end
            kcl_pkg::CSR_OPEN_TICKS: begin
               open_ticks_ff <= csr_wdata[kcl_pkg::TIMER_W-1:0];
            end
            default: begin
               stored_code_ff <= stored_code_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         entry_count_ff  <= '0;
         entering_ff     <= 1'b0;
         idle_ticks_ff   <= '0;
         lock_open_ff    <= 1'b0;
         open_elapsed_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         rsp_event_ff    <= kcl_pkg::EV_NONE;
      end else begin
         in_valid_ff     <= in_valid_in;
         entry_count_ff  <= entry_count_in;
         entering_ff     <= entering_in;
         idle_ticks_ff   <= idle_ticks_in;
         lock_open_ff    <= lock_open_in;
         open_elapsed_ff <= open_elapsed_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_event_ff    <= rsp_event_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff  <= req_op;
         in_key_ff <= req_key;
      end
      if (digit_wr) begin
         entry_digits_ff[entry_count_ff[kcl_pkg::DIGIT_IDX_W-1:0]] <= in_key_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = rsp_event_ff;
   assign rsp_door_open   = lock_open_ff;
   assign rsp_digit_count = entry_count_ff;

   // entry and open door exclude each other
   a_open_no_entry: assert property (@(posedge clock) disable iff (reset)
      !(lock_open_ff && entering_ff))
      else $error("entry active while door open");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= kcl_pkg::COUNT_W'(kcl_pkg::MAX_DIGITS))
      else $error("digit count above buffer depth");

   a_accept_opens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_event_ff == kcl_pkg::EV_ACCEPT) |-> rsp_door_open)
      else $error("accept result without open door");

   a_close_locks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_event_ff == kcl_pkg::EV_CLOSED) |-> !rsp_door_open)
      else $error("closed result with open door");

   a_timeout_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_event_ff == kcl_pkg::EV_TIMEOUT) |->
         (rsp_digit_count == '0) && !entering_ff)
      else $error("timeout left entry state behind");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_key_ff) && $stable(in_op_ff))
      else $error("input word lost during stall");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for keypad_code_lock_unit: key/tick words in, one status word out each.
// Holds its own lock predictor in a small scoreboard class; plain tasks drive the ports.
// Depends on kcl_pkg and keypad_code_lock_unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 400;
   localparam logic [kcl_pkg::DIGIT_W-1:0] KEY_UNKNOWN = 4'd15;

   typedef struct packed {
      kcl_pkg::event_type          ev;
      logic                        door;
      logic [kcl_pkg::COUNT_W-1:0] fill;
   } lock_status;

   class lock_scoreboard;
      logic [kcl_pkg::CODE_W-1:0]   pin_code;
      logic [kcl_pkg::LENGTH_W-1:0] pin_len;
      logic [kcl_pkg::TIMER_W-1:0]  entry_limit;
      logic [kcl_pkg::TIMER_W-1:0]  hold_limit;
      logic [kcl_pkg::DIGIT_W-1:0]  keyed [kcl_pkg::MAX_DIGITS];
      logic [kcl_pkg::COUNT_W-1:0]  fill;
      logic                         in_entry;
      logic                         unlocked;
      logic [kcl_pkg::TIMER_W-1:0]  idle_age;
      logic [kcl_pkg::TIMER_W-1:0]  open_age;
      lock_status                   expected_q[$];
      int                           errors;
      int                           words;
      int                           active_words;
      int                           peak_fill;
      int                           tally [6];

      function new();
         pin_code    = '0;
         pin_len     = '0;
         entry_limit = kcl_pkg::ENTRY_TIMEOUT_RST;
         hold_limit  = kcl_pkg::OPEN_TICKS_RST;
         fill        = '0;
         in_entry    = 1'b0;
         unlocked    = 1'b0;
         idle_age    = '0;
         open_age    = '0;
         errors      = 0;
         words       = 0;
         active_words = 0;
         peak_fill   = 0;
         foreach (keyed[i]) keyed[i] = '0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      function void set_reg(logic [kcl_pkg::CSR_INDEX_W-1:0] idx,
                            logic [kcl_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            kcl_pkg::CSR_STORED_CODE:   pin_code = data[kcl_pkg::CODE_W-1:0];
            kcl_pkg::CSR_STORED_LENGTH: pin_len = data[kcl_pkg::LENGTH_W-1:0];
            kcl_pkg::CSR_ENTRY_TIMEOUT: entry_limit = data[kcl_pkg::TIMER_W-1:0];
            kcl_pkg::CSR_OPEN_TICKS:    hold_limit = data[kcl_pkg::TIMER_W-1:0];
            default: ;
         endcase
      endfunction

      function bit pin_matches();
         int i;
         if (pin_len == 0 || pin_len > kcl_pkg::MAX_DIGITS || fill != pin_len) return 1'b0;
         for (i = 0; i < kcl_pkg::MAX_DIGITS; i++)
            if (i < fill && keyed[i] != pin_code[kcl_pkg::DIGIT_W*i +: kcl_pkg::DIGIT_W])
               return 1'b0;
         return 1'b1;
      endfunction

      // advance the lock by one accepted word and queue the status it must produce
      function void note_word(logic op, logic [kcl_pkg::DIGIT_W-1:0] key);
         lock_status s;
         logic [kcl_pkg::COUNT_W+2*kcl_pkg::TIMER_W+1:0] prior;
         prior = {fill, in_entry, unlocked, idle_age, open_age};
         s.ev = kcl_pkg::EV_NONE;
         if (op == kcl_pkg::OP_TICK) begin
            if (unlocked) begin
               if (open_age >= hold_limit) begin
                  unlocked = 1'b0;
                  s.ev = kcl_pkg::EV_CLOSED;
               end else begin
                  open_age++;
               end
            end else if (in_entry) begin
               if (idle_age >= entry_limit) begin
                  in_entry = 1'b0;
                  fill = '0;
                  s.ev = kcl_pkg::EV_TIMEOUT;
               end else begin
                  idle_age++;
               end
            end
         end else if (!unlocked && key <= kcl_pkg::KEY_HASH) begin
            // any real key on a closed door restarts the idle count
            idle_age = '0;
            if (key == kcl_pkg::KEY_STAR) begin
               fill = '0;
               in_entry = 1'b1;
               s.ev = kcl_pkg::EV_START;
            end else if (key == kcl_pkg::KEY_HASH) begin
               if (in_entry && fill != 0) begin
                  in_entry = 1'b0;
                  if (pin_matches()) begin
                     unlocked = 1'b1;
                     open_age = '0;
                     s.ev = kcl_pkg::EV_ACCEPT;
                  end else begin
                     s.ev = kcl_pkg::EV_REJECT;
                  end
               end
            end else if (in_entry && fill < kcl_pkg::MAX_DIGITS) begin
               keyed[fill[kcl_pkg::DIGIT_IDX_W-1:0]] = key;
               fill++;
            end
         end
         s.door = unlocked;
         s.fill = fill;
         words++;
         if (s.ev != kcl_pkg::EV_NONE || prior != {fill, in_entry, unlocked, idle_age, open_age})
            active_words++;
         if (fill > peak_fill) peak_fill = fill;
         tally[s.ev]++;
         expected_q.push_back(s);
      endfunction

      function void report_mismatch(string field, logic [7:0] want, logic [7:0] got);
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_result(logic [kcl_pkg::EVENT_W-1:0] ev, logic door,
                                 logic [kcl_pkg::COUNT_W-1:0] cnt);
         lock_status s;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: status word with nothing expected: event %0d door %0d count %0d",
                     $time, ev, door, cnt);
            return;
         end
         s = expected_q.pop_front();
         if (ev !== s.ev) report_mismatch("event_res", s.ev, ev);
         if (door !== s.door) report_mismatch("door_open", s.door, door);
         if (cnt !== s.fill) report_mismatch("digit_count", s.fill, cnt);
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_op = kcl_pkg::OP_KEY;
   logic [kcl_pkg::DIGIT_W-1:0]     req_key = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [kcl_pkg::EVENT_W-1:0]     rsp_event_res;
   logic                            rsp_door_open;
   logic [kcl_pkg::COUNT_W-1:0]     rsp_digit_count;
   logic                            csr_wr_en = 1'b0;
   logic [kcl_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [kcl_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   lock_scoreboard sb = new();

   bit                         gaps_on = 1'b1;
   bit                         stalls_on = 1'b1;
   int                         gap_pct = 15;
   int                         quiet_cycles = 0;
   int                         settings = 0;
   logic [kcl_pkg::CODE_W-1:0] cur_code;
   int                         cur_len;
   int                         cur_timeout;
   int                         cur_open;

   keypad_code_lock_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_door_open   (rsp_door_open),
      .rsp_digit_count (rsp_digit_count),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // both handshakes are sampled at the edge, before any of this step's updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_word(req_op, req_key);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_event_res, rsp_door_open, rsp_digit_count);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_top: errors");
      $finish;
   end

   // receiver: stall bursts mixed with stretches of steady ready
   initial begin
      @(posedge clock);
      forever begin
         if (stalls_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   task automatic send_word(input logic op, input logic [kcl_pkg::DIGIT_W-1:0] key);
      if (gaps_on && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic press(input logic [kcl_pkg::DIGIT_W-1:0] key);
      send_word(kcl_pkg::OP_KEY, key);
   endtask

   // key field is don't-care on a tick, so fill it with noise
   task automatic tick_word();
      send_word(kcl_pkg::OP_TICK, 4'($urandom_range(0, 15)));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.expected_q.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [kcl_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [kcl_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.set_reg(idx, data);
      @(posedge clock);
   endtask

   // narrow registers get junk above their width; the block must ignore it
   task automatic configure(input logic [kcl_pkg::CODE_W-1:0] code, input int len,
                            input int tmo, input int opn);
      logic [kcl_pkg::CSR_DATA_W-1:0] junk;
      wait_drained();
      junk = {$urandom, $urandom};
      write_reg(kcl_pkg::CSR_STORED_CODE, code);
      write_reg(kcl_pkg::CSR_STORED_LENGTH,
                {junk[kcl_pkg::CSR_DATA_W-1:kcl_pkg::LENGTH_W], kcl_pkg::LENGTH_W'(len)});
      write_reg(kcl_pkg::CSR_ENTRY_TIMEOUT,
                {junk[kcl_pkg::CSR_DATA_W-1:kcl_pkg::TIMER_W], kcl_pkg::TIMER_W'(tmo)});
      write_reg(kcl_pkg::CSR_OPEN_TICKS,
                {junk[kcl_pkg::CSR_DATA_W-1:kcl_pkg::TIMER_W], kcl_pkg::TIMER_W'(opn)});
      csr_wr_en <= 1'b0;
      cur_code    = code;
      cur_len     = len;
      cur_timeout = tmo;
      cur_open    = opn;
      settings++;
   endtask

   function automatic logic [kcl_pkg::CODE_W-1:0] rand_code();
      logic [kcl_pkg::CODE_W-1:0] c;
      int i;
      for (i = 0; i < kcl_pkg::MAX_DIGITS; i++)
         c[kcl_pkg::DIGIT_W*i +: kcl_pkg::DIGIT_W] = 4'($urandom_range(0, 9));
      return c;
   endfunction

   // enough ticks to land just short of, on, or past a small limit
   function automatic int wait_ticks(input int hold);
      return (hold < 24) ? hold + $urandom_range(0, 2) : $urandom_range(0, 4);
   endfunction

   task automatic entry_attempt();
      int mode;
      int n;
      int i;
      logic [kcl_pkg::DIGIT_W-1:0] d;
      mode = $urandom_range(0, 9);
      if (mode < 6 && cur_len >= 1 && cur_len <= kcl_pkg::MAX_DIGITS) n = cur_len;
      else if (mode < 8) n = $urandom_range(0, kcl_pkg::MAX_DIGITS + 2);
      else n = $urandom_range(1, kcl_pkg::MAX_DIGITS);
      press(kcl_pkg::KEY_STAR);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 11) == 0) tick_word();
         if ($urandom_range(0, 29) == 0) press(4'($urandom_range(12, 15)));
         d = cur_code[kcl_pkg::DIGIT_W*(i % kcl_pkg::MAX_DIGITS) +: kcl_pkg::DIGIT_W];
         if (mode >= 5 || d > 9 || $urandom_range(0, 19) == 0) d = 4'($urandom_range(0, 9));
         press(d);
      end
      if (mode == 9) begin
         // walk away from the keypad and let the entry expire
         repeat (wait_ticks(cur_timeout)) tick_word();
      end else begin
         press(kcl_pkg::KEY_HASH);
         repeat ($urandom_range(0, 2)) press(4'($urandom_range(0, 15)));
         repeat (wait_ticks(cur_open)) tick_word();
      end
   endtask

   task automatic run_phase(input logic [kcl_pkg::CODE_W-1:0] code, input int len,
                            input int tmo, input int opn, input int target,
                            input bit hold_midway);
      int start;
      bit held;
      configure(code, len, tmo, opn);
      gap_pct = 12 * $urandom_range(0, 2);
      start = sb.words;
      held = 1'b0;
      while (sb.words - start < target) begin
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6))
               send_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
         else
            entry_attempt();
         if (hold_midway && !held && sb.words - start >= target / 2) begin
            wait_drained();
            held = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: code 9,0,5,3, short timers
      configure(64'h3509, 4, 2, 1);
      press(4'd5);
      press(kcl_pkg::KEY_HASH);
      press(KEY_UNKNOWN);
      press(kcl_pkg::KEY_STAR);
      press(kcl_pkg::KEY_HASH);
      press(4'd9);
      press(4'd0);
      press(4'd5);
      press(4'd3);
      press(kcl_pkg::KEY_HASH);
      press(kcl_pkg::KEY_STAR);
      tick_word();
      tick_word();
      press(kcl_pkg::KEY_STAR);
      press(4'd9);
      press(4'd0);
      press(4'd5);
      press(kcl_pkg::KEY_HASH);
      press(kcl_pkg::KEY_STAR);
      press(4'd1);
      repeat (4) tick_word();

      run_phase(rand_code(), kcl_pkg::MAX_DIGITS, 0, 0, 80, 1'b0);
      run_phase(rand_code(), 1, 1, 1, 80, 1'b1);
      run_phase({kcl_pkg::CODE_W{1'b1}}, kcl_pkg::MAX_DIGITS, 65535, 65535, 35, 1'b0);
      run_phase(rand_code(), $urandom_range(kcl_pkg::MAX_DIGITS + 1, 31), 5, 3, 70, 1'b0);
      run_phase('0, 0, $urandom_range(2, 12), $urandom_range(2, 12), 70, 1'b0);
      run_phase('0, $urandom_range(1, kcl_pkg::MAX_DIGITS), $urandom_range(2, 12),
                $urandom_range(2, 12), 80, 1'b0);
      run_phase(rand_code(), $urandom_range(1, kcl_pkg::MAX_DIGITS), $urandom_range(0, 20),
                $urandom_range(0, 20), 100, 1'b0);
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      run_phase(rand_code(), $urandom_range(1, kcl_pkg::MAX_DIGITS), $urandom_range(2, 20),
                $urandom_range(2, 20), 90, 1'b0);

      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d expected status words never arrived", $time, sb.expected_q.size());
      end

      $display("Drove %0d words (%0d changed state) under %0d register settings, buffer peak %0d",
               sb.words, sb.active_words, settings, sb.peak_fill);
      $display("Events: %0d starts, %0d opens, %0d rejects, %0d entry timeouts, %0d closings",
               sb.tally[kcl_pkg::EV_START], sb.tally[kcl_pkg::EV_ACCEPT],
               sb.tally[kcl_pkg::EV_REJECT], sb.tally[kcl_pkg::EV_TIMEOUT],
               sb.tally[kcl_pkg::EV_CLOSED]);
      if (sb.errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/kcl_pkg.sv
hw/rtl/keypad_code_lock_unit.sv
verif/tb_top.sv
